// ===== hw/rtl/sfa_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfa_pkg: shared types and constants for the spring force accumulator
// Widths of the fixed-point fields and the sequencer state encoding.
// ----------------------------------------------------------------------------
package sfa_pkg;

    localparam int DATA_W         = 32;
    localparam int FRAC_BITS_DEF  = 16;
    localparam int ACC_WIDTH_DEF  = 48;
    localparam int SUMSQ_W        = 64;
    localparam int ROOT_W         = 32;
    localparam int PROD_W         = 64;

    localparam logic CMD_START  = 1'b0;
    localparam logic CMD_SPRING = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SQ,
        ST_ROOT,
        ST_MUL,
        ST_DIV,
        ST_ADD,
        ST_OUT
    } sfa_state_t;

    // request from sequencer to the shared divider
    typedef struct packed {
        logic              start;
        logic [PROD_W-1:0] num;
        logic [ROOT_W-1:0] den;
    } sfa_div_req_t;

    typedef struct packed {
        logic              done;
        logic [PROD_W-1:0] quo;
    } sfa_div_rsp_t;

endpackage

// ===== hw/rtl/spring_force_accumulator_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spring_force_accumulator_unit: resultant force on one mass node
// Sequencer around a shared multiplier, square root and divider.
// ----------------------------------------------------------------------------
// Usage: drive a beat with start high while busy is low. command 0 loads the
// node position and sets the sums to external plus collision force; busy
// stays low after it unless last is set. command 1 adds one spring term:
// three squares on the shared multiplier, a square root, then per axis one
// multiply, a 64-step divide and an add. A zero length skips the divides.
// With last high, one output step follows the update and the result beat
// comes in the cycle after it: force_x/y/z and saturated with valid high for
// exactly one cycle. The next beat can be taken in that same cycle. The
// receiver cannot stall; the result is simply presented.
// Reset clears position and sums to zero and returns to idle.
// ----------------------------------------------------------------------------
module spring_force_accumulator_unit #(
    parameter int FRAC_BITS = sfa_pkg::FRAC_BITS_DEF,
    parameter int ACC_WIDTH = sfa_pkg::ACC_WIDTH_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic                               command,
    input  logic signed [sfa_pkg::DATA_W-1:0]  pos_x,
    input  logic signed [sfa_pkg::DATA_W-1:0]  pos_y,
    input  logic signed [sfa_pkg::DATA_W-1:0]  pos_z,
    input  logic signed [sfa_pkg::DATA_W-1:0]  ext_x,
    input  logic signed [sfa_pkg::DATA_W-1:0]  ext_y,
    input  logic signed [sfa_pkg::DATA_W-1:0]  ext_z,
    input  logic signed [sfa_pkg::DATA_W-1:0]  col_x,
    input  logic signed [sfa_pkg::DATA_W-1:0]  col_y,
    input  logic signed [sfa_pkg::DATA_W-1:0]  col_z,
    input  logic signed [sfa_pkg::DATA_W-1:0]  magnitude,
    input  logic                               last,
    output logic                               valid,
    output logic signed [sfa_pkg::DATA_W-1:0]  force_x,
    output logic signed [sfa_pkg::DATA_W-1:0]  force_y,
    output logic signed [sfa_pkg::DATA_W-1:0]  force_z,
    output logic                               saturated
);
    import sfa_pkg::*;

    // the format cancels out of d / L; the fraction width only bounds range
    localparam int FRAC_CHK = (FRAC_BITS < DATA_W) ? 1 : 0;
    localparam int AW       = ACC_WIDTH;

    localparam logic signed [AW-1:0] ACC_MAX = {1'b0, {(AW-1){1'b1}}};
    localparam logic signed [AW-1:0] ACC_MIN = {1'b1, {(AW-1){1'b0}}};
    localparam logic signed [AW-1:0] OUT_MAX = AW'(64'sd2147483647);
    localparam logic signed [AW-1:0] OUT_MIN = AW'(-64'sd2147483648);

    sfa_state_t state_reg, state_next;

    logic signed [DATA_W-1:0] own_reg [3];
    logic signed [AW-1:0]     sum_reg [3];
    logic [DATA_W-1:0]        mag_reg [3];
    logic                     neg_reg [3];
    logic [DATA_W-1:0]        mm_reg;
    logic                     mneg_reg;
    logic                     last_reg;
    logic [SUMSQ_W-1:0]       s_reg;
    logic [ROOT_W-1:0]        len_reg;
    logic [PROD_W-1:0]        prod_reg;
    logic [1:0]               axis_reg;

    logic valid_reg;
    logic signed [DATA_W-1:0] fout_reg [3];
    logic sat_reg;

    // shared 32x32 multiplier
    logic [DATA_W-1:0] mul_a, mul_b;
    logic [PROD_W-1:0] mul_p;
    assign mul_p = PROD_W'(mul_a) * PROD_W'(mul_b);

    logic               sq_start, sq_done;
    logic [ROOT_W-1:0]  sq_root;
    logic [SUMSQ_W-1:0] sq_rad;
    sfa_div_req_t       div_req;
    sfa_div_rsp_t       div_rsp;

    // the root starts on the last square, so fold that square in here
    assign sq_rad = s_reg + mul_p;

    sfa_isqrt u_isqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (sq_start),
        .radicand (sq_rad),
        .done     (sq_done),
        .root     (sq_root)
    );

    sfa_divider u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    logic accept;
    assign accept = start && !busy;

    // difference vector of the incoming beat
    logic signed [DATA_W:0] dif [3];
    logic [DATA_W:0]        dabs [3];
    logic                   big;
    logic signed [DATA_W-1:0] pin [3];
    assign pin[0] = pos_x;
    assign pin[1] = pos_y;
    assign pin[2] = pos_z;

    always_comb
    begin
        big = 1'b0;
        for (int i = 0; i < 3; i++)
        begin
            dif[i]  = (DATA_W+1)'(pin[i]) - (DATA_W+1)'(own_reg[i]);
            dabs[i] = dif[i][DATA_W] ? (DATA_W+1)'(-dif[i]) : dif[i];
            if (dabs[i][DATA_W:DATA_W-1] != 2'b00)
                big = 1'b1;
        end
    end

    // saturating accumulate of a signed term into the selected axis
    logic signed [AW:0]   acc_wide;
    logic signed [AW-1:0] acc_new;
    logic signed [PROD_W:0] term;
    logic signed [AW+1:0] term_c;

    always_comb
    begin
        term = neg_reg[axis_reg] != mneg_reg ? -$signed({1'b0, prod_reg})
                                             : $signed({1'b0, prod_reg});
        // |term| <= |magnitude| so it fits in 33 bits
        term_c   = (AW+2)'($signed(term[DATA_W:0]));
        acc_wide = (AW+1)'(sum_reg[axis_reg]) + (AW+1)'(term_c);
        if (acc_wide > (AW+1)'(ACC_MAX))
            acc_new = ACC_MAX;
        else if (acc_wide < (AW+1)'(ACC_MIN))
            acc_new = ACC_MIN;
        else
            acc_new = acc_wide[AW-1:0];
    end

    logic signed [AW:0] start_wide [3];
    logic signed [DATA_W-1:0] ein [3], cin [3];
    assign ein[0] = ext_x;
    assign ein[1] = ext_y;
    assign ein[2] = ext_z;
    assign cin[0] = col_x;
    assign cin[1] = col_y;
    assign cin[2] = col_z;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
            start_wide[i] = (AW+1)'(ein[i]) + (AW+1)'(cin[i]);
    end

    always_comb
    begin
        state_next   = state_reg;
        sq_start     = 1'b0;
        div_req.start = 1'b0;
        div_req.num  = mul_p;
        div_req.den  = len_reg;
        mul_a        = mag_reg[axis_reg];
        mul_b        = mag_reg[axis_reg];
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (command == CMD_START)
                        state_next = last ? ST_OUT : ST_IDLE;
                    else
                        state_next = ST_SQ;
                end
            end
            ST_SQ:
            begin
                if (axis_reg == 2'd2)
                    state_next = ST_ROOT;
            end
            ST_ROOT:
            begin
                if (sq_done)
                    state_next = (sq_root == '0) ? (last_reg ? ST_OUT : ST_IDLE)
                                                 : ST_MUL;
            end
            ST_MUL:
            begin
                mul_a      = mm_reg;
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                if (div_rsp.done)
                    state_next = ST_ADD;
            end
            ST_ADD:
            begin
                if (axis_reg == 2'd2)
                    state_next = last_reg ? ST_OUT : ST_IDLE;
                else
                    state_next = ST_MUL;
            end
            ST_OUT:  state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
        if (state_reg == ST_SQ && axis_reg == 2'd2)
            sq_start = 1'b1;
        if (state_reg == ST_MUL)
            div_req.start = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            valid_reg <= 1'b0;
            axis_reg  <= '0;
            for (int i = 0; i < 3; i++)
            begin
                own_reg[i] <= '0;
                sum_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            valid_reg <= (state_reg == ST_OUT);
            case (state_reg)
                ST_IDLE:
                begin
                    axis_reg <= '0;
                    if (accept && command == CMD_START)
                    begin
                        for (int i = 0; i < 3; i++)
                        begin
                            own_reg[i] <= pin[i];
                            if (start_wide[i] > (AW+1)'(ACC_MAX))
                                sum_reg[i] <= ACC_MAX;
                            else if (start_wide[i] < (AW+1)'(ACC_MIN))
                                sum_reg[i] <= ACC_MIN;
                            else
                                sum_reg[i] <= start_wide[i][AW-1:0];
                        end
                    end
                end
                ST_SQ:
                begin
                    axis_reg <= (axis_reg == 2'd2) ? 2'd0 : axis_reg + 2'd1;
                end
                ST_ADD:
                begin
                    sum_reg[axis_reg] <= acc_new;
                    axis_reg <= (axis_reg == 2'd2) ? 2'd0 : axis_reg + 2'd1;
                end
                default: ;
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            last_reg <= last;
            mneg_reg <= magnitude[DATA_W-1];
            mm_reg   <= magnitude[DATA_W-1] ? DATA_W'(-magnitude) : magnitude;
            s_reg    <= '0;
            for (int i = 0; i < 3; i++)
            begin
                neg_reg[i] <= dif[i][DATA_W];
                mag_reg[i] <= big ? dabs[i][DATA_W:1] : dabs[i][DATA_W-1:0];
            end
        end
        else
        begin
            case (state_reg)
                ST_SQ:   s_reg <= s_reg + mul_p;
                ST_ROOT: len_reg <= sq_root;
                ST_MUL:  prod_reg <= mul_p;
                ST_DIV:  prod_reg <= div_rsp.quo;
                default: ;
            endcase
        end
    end

    // hold the div product for the request: div uses mul_p directly
    // (prod_reg is loaded the same cycle the divider starts)

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_OUT)
        begin
            sat_reg <= 1'b0;
            for (int i = 0; i < 3; i++)
            begin
                if (sum_reg[i] > OUT_MAX)
                    fout_reg[i] <= 32'sh7fffffff;
                else if (sum_reg[i] < OUT_MIN)
                    fout_reg[i] <= 32'sh80000000;
                else
                    fout_reg[i] <= sum_reg[i][DATA_W-1:0];
            end
            if (sum_reg[0] > OUT_MAX || sum_reg[0] < OUT_MIN ||
                sum_reg[1] > OUT_MAX || sum_reg[1] < OUT_MIN ||
                sum_reg[2] > OUT_MAX || sum_reg[2] < OUT_MIN)
                sat_reg <= 1'b1;
        end
    end

    assign busy      = (state_reg != ST_IDLE) || (FRAC_CHK == 0);
    assign valid     = valid_reg;
    assign force_x   = fout_reg[0];
    assign force_y   = fout_reg[1];
    assign force_z   = fout_reg[2];
    assign saturated = sat_reg;

    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE) |-> busy)
        else $error("busy low while working");
    a_valid_after_out: assert property (@(posedge clk) disable iff (!rst_n)
        valid |-> $past(state_reg == ST_OUT))
        else $error("result without output step");
    a_valid_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        valid |=> !valid)
        else $error("result strobe longer than one cycle");

endmodule

// ===== hw/rtl/sfa_isqrt.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfa_isqrt: iterative integer square root
// Two radicand bits per cycle for a 64-bit radicand, giving a 32-bit root.
// ----------------------------------------------------------------------------
module sfa_isqrt (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [sfa_pkg::SUMSQ_W-1:0] radicand,
    output logic                        done,
    output logic [sfa_pkg::ROOT_W-1:0]  root
);
    import sfa_pkg::*;

    localparam int STEPS = SUMSQ_W / 2;
    localparam int CNT_W = $clog2(STEPS + 1);

    logic [SUMSQ_W-1:0] rad_reg;
    logic [ROOT_W+1:0]  rem_reg;
    logic [ROOT_W-1:0]  root_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic               busy_reg;
    logic               done_reg;

    logic [ROOT_W+1:0] rem_shift;
    logic [ROOT_W+1:0] trial;
    logic              fits;

    assign rem_shift = {rem_reg[ROOT_W-1:0], rad_reg[SUMSQ_W-1 -: 2]};
    assign trial     = {root_reg, 2'b01};
    assign fits      = rem_shift >= trial;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(STEPS);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rad_reg  <= radicand;
            rem_reg  <= '0;
            root_reg <= '0;
        end
        else if (busy_reg)
        begin
            rad_reg  <= {rad_reg[SUMSQ_W-3:0], 2'b00};
            rem_reg  <= fits ? rem_shift - trial : rem_shift;
            root_reg <= {root_reg[ROOT_W-2:0], fits};
        end
    end

    assign done = done_reg;
    assign root = root_reg;

endmodule

// ===== hw/rtl/sfa_divider.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfa_divider: restoring unsigned divider, one quotient bit per cycle
// 64-bit dividend by 32-bit divisor, giving a 64-bit quotient.
// ----------------------------------------------------------------------------
module sfa_divider (
    input  logic                clk,
    input  logic                rst_n,
    input  sfa_pkg::sfa_div_req_t req,
    output sfa_pkg::sfa_div_rsp_t rsp
);
    import sfa_pkg::*;

    localparam int CNT_W = $clog2(PROD_W + 1);

    logic [PROD_W-1:0] quo_reg;
    logic [ROOT_W:0]   rem_reg;
    logic [ROOT_W-1:0] den_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic              busy_reg;
    logic              done_reg;

    logic [ROOT_W:0] rem_shift;
    logic            fits;

    assign rem_shift = {rem_reg[ROOT_W-1:0], quo_reg[PROD_W-1]};
    assign fits      = rem_shift >= {1'b0, den_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(PROD_W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            quo_reg <= req.num;
            rem_reg <= '0;
            den_reg <= req.den;
        end
        else if (busy_reg)
        begin
            rem_reg <= fits ? rem_shift - {1'b0, den_reg} : rem_shift;
            quo_reg <= {quo_reg[PROD_W-2:0], fits};
        end
    end

    assign rsp.done = done_reg;
    assign rsp.quo  = quo_reg;

endmodule

// ===== bench/spring_force_accumulator_unit_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spring_force_accumulator_unit_tb: self-checking bench for the force unit
// Drives start and spring beats, predicts each resultant force from its own
// model of the node state and compares every result beat field by field.
// ----------------------------------------------------------------------------
module spring_force_accumulator_unit_tb;

    import sfa_pkg::*;

    typedef logic signed [DATA_W-1:0] word_t;

    typedef struct {
        word_t fx;
        word_t fy;
        word_t fz;
        logic  sat;
    } node_force_t;

    localparam longint ACC_HI = (64'sd1 <<< (ACC_WIDTH_DEF - 1)) - 1;
    localparam longint ACC_LO = -ACC_HI - 1;

    logic  clk = 1'b0;
    logic  rst_n = 1'b0;
    logic  start = 1'b0;
    logic  command = CMD_START;
    word_t pos_x = '0, pos_y = '0, pos_z = '0;
    word_t ext_x = '0, ext_y = '0, ext_z = '0;
    word_t col_x = '0, col_y = '0, col_z = '0;
    word_t magnitude = '0;
    logic  last = 1'b0;
    logic  busy, valid, saturated;
    word_t force_x, force_y, force_z;

    // model state of the node
    word_t       node_pos [3];
    longint      node_sum [3];
    node_force_t pending_forces [$];
    int          mismatch_count = 0;
    bit          gaps_on = 1'b1;

    spring_force_accumulator_unit dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .command(command),
        .pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z),
        .ext_x(ext_x), .ext_y(ext_y), .ext_z(ext_z),
        .col_x(col_x), .col_y(col_y), .col_z(col_z),
        .magnitude(magnitude), .last(last),
        .valid(valid), .force_x(force_x), .force_y(force_y), .force_z(force_z),
        .saturated(saturated)
    );

    always #5 clk = ~clk;

    function automatic longint sum_add(longint a, longint t);
        longint x;
        x = a;
        if (x > ACC_HI) x = ACC_HI;
        if (x < ACC_LO) x = ACC_LO;
        if (t > 0 && x > ACC_HI - t) return ACC_HI;
        if (t < 0 && x < ACC_LO - t) return ACC_LO;
        return x + t;
    endfunction

    function automatic longint unsigned int_sqrt(longint unsigned s);
        longint unsigned res;
        longint unsigned b;
        longint unsigned rem;
        res = 0;
        rem = s;
        b = 64'h4000_0000_0000_0000;
        while (b > rem) b = b >> 2;
        while (b != 0)
        begin
            if (rem >= res + b)
            begin
                rem = rem - (res + b);
                res = (res >> 1) + b;
            end
            else
                res = res >> 1;
            b = b >> 2;
        end
        return res;
    endfunction

    task automatic apply_spring(word_t p [3], word_t mag);
        longint          d;
        longint          m;
        longint          t;
        longint unsigned mm, s, len, q;
        longint unsigned dm [3];
        bit              dn [3];
        bit              big;
        big = 1'b0;
        s = 0;
        m = mag;
        mm = (m < 0) ? -m : m;
        for (int i = 0; i < 3; i++)
        begin
            d = longint'(p[i]) - longint'(node_pos[i]);
            dn[i] = d < 0;
            dm[i] = dn[i] ? -d : d;
            if (dm[i] >= 64'h8000_0000) big = 1'b1;
        end
        for (int i = 0; i < 3; i++)
        begin
            if (big) dm[i] = dm[i] >> 1;
            s = s + dm[i] * dm[i];
        end
        len = int_sqrt(s);
        if (len != 0)
        begin
            for (int i = 0; i < 3; i++)
            begin
                q = (mm * dm[i]) / len;
                t = q;
                if ((m < 0) != dn[i]) t = -t;
                node_sum[i] = sum_add(node_sum[i], t);
            end
        end
    endtask

    task automatic predict_beat(logic cmd, word_t p [3], word_t e [3], word_t c [3],
                                word_t mag, logic lst);
        node_force_t r;
        longint      v [3];
        if (cmd == CMD_START)
        begin
            for (int i = 0; i < 3; i++)
            begin
                node_pos[i] = p[i];
                node_sum[i] = sum_add(longint'(e[i]), longint'(c[i]));
            end
        end
        else
            apply_spring(p, mag);
        if (lst)
        begin
            r.sat = 1'b0;
            for (int i = 0; i < 3; i++)
            begin
                v[i] = node_sum[i];
                if (v[i] > 64'sd2147483647) begin v[i] = 64'sd2147483647; r.sat = 1'b1; end
                if (v[i] < -64'sd2147483648) begin v[i] = -64'sd2147483648; r.sat = 1'b1; end
            end
            r.fx = v[0][31:0];
            r.fy = v[1][31:0];
            r.fz = v[2][31:0];
            pending_forces.push_back(r);
        end
    endtask

    // drive one beat, hold it until the unit takes it, then predict
    task automatic send_beat(logic cmd, word_t p [3], word_t e [3], word_t c [3],
                             word_t mag, logic lst);
        if (gaps_on && $urandom_range(0, 99) < 10)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        start <= 1'b1;
        command <= cmd;
        pos_x <= p[0]; pos_y <= p[1]; pos_z <= p[2];
        ext_x <= e[0]; ext_y <= e[1]; ext_z <= e[2];
        col_x <= c[0]; col_y <= c[1]; col_z <= c[2];
        magnitude <= mag;
        last <= lst;
        do @(posedge clk); while (busy);
        predict_beat(cmd, p, e, c, mag, lst);
    endtask

    function automatic word_t rand_word();
        case ($urandom_range(0, 5))
            0: return 32'sh7FFF_FFFF;
            1: return 32'sh8000_0000;
            2: return word_t'($urandom_range(0, 200)) - 100;
            default: return word_t'($urandom);
        endcase
    endfunction

    task automatic start_node(word_t p [3], word_t e [3], word_t c [3], logic lst);
        send_beat(CMD_START, p, e, c, rand_word(), lst);
    endtask

    task automatic add_spring(word_t p [3], word_t mag, logic lst);
        word_t junk [3];
        foreach (junk[i]) junk[i] = word_t'($urandom);
        send_beat(CMD_SPRING, p, junk, junk, mag, lst);
    endtask

    task automatic report_mismatch(string what, word_t got, word_t want);
        mismatch_count++;
        $display("MISMATCH %s: got %0d, want %0d at %0t", what, got, want, $realtime);
    endtask

    always @(posedge clk)
    begin
        node_force_t w;
        if (rst_n && valid)
        begin
            if (pending_forces.size() == 0)
            begin
                mismatch_count++;
                $display("MISMATCH unexpected result beat at %0t", $realtime);
            end
            else
            begin
                w = pending_forces.pop_front();
                if (force_x !== w.fx) report_mismatch("force_x", force_x, w.fx);
                if (force_y !== w.fy) report_mismatch("force_y", force_y, w.fy);
                if (force_z !== w.fz) report_mismatch("force_z", force_z, w.fz);
                if (saturated !== w.sat)
                    report_mismatch("saturated", word_t'(saturated), word_t'(w.sat));
            end
        end
    end

    // springs right after reset run against a zero node
    task automatic test_orphan_springs();
        word_t p [3] = '{32'sd65536, -32'sd65536, 32'sd0};
        add_spring(p, 32'sd131072, 1'b1);
        add_spring(p, -32'sd131072, 1'b0);
        add_spring('{32'sd0, 32'sd0, 32'sd0}, 32'sh7FFF_FFFF, 1'b1);
    endtask

    task automatic test_extremes();
        word_t hi [3] = '{32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF};
        word_t lo [3] = '{32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000};
        word_t zr [3] = '{32'sd0, 32'sd0, 32'sd0};
        start_node(hi, hi, hi, 1'b1);
        start_node(lo, lo, lo, 1'b1);
        start_node(hi, lo, hi, 1'b0);
        add_spring(lo, 32'sh8000_0000, 1'b0);
        add_spring(lo, 32'sh7FFF_FFFF, 1'b1);
        start_node(lo, zr, zr, 1'b0);
        add_spring(hi, 32'sh7FFF_FFFF, 1'b0);
        add_spring('{32'sh7FFF_FFFF, 32'sh8000_0000, 32'sd0}, 32'sh8000_0000, 1'b1);
        start_node(zr, hi, hi, 1'b0);
        add_spring('{32'sd1, 32'sd0, 32'sd0}, 32'sh7FFF_FFFF, 1'b1);
    endtask

    task automatic test_zero_length();
        word_t p [3] = '{32'sd12345, -32'sd777, 32'sd99};
        start_node(p, '{32'sd1, 32'sd2, 32'sd3}, '{-32'sd4, 32'sd5, 32'sd6}, 1'b0);
        add_spring(p, 32'sh7FFF_FFFF, 1'b1);
        // keep summing on the old node after its last beat
        add_spring('{32'sd12346, -32'sd777, 32'sd99}, -32'sd65536, 1'b1);
        add_spring('{32'sd0, 32'sd0, 32'sd0}, 32'sd65536, 1'b0);
    endtask

    task automatic test_random_nodes(int n_items);
        int    sent;
        int    springs;
        word_t own [3];
        word_t p [3];
        word_t e [3];
        word_t c [3];
        sent = 0;
        while (sent < n_items)
        begin
            gaps_on = !(sent > n_items / 3 && sent < n_items / 2);
            if ($urandom_range(0, 9) == 0)
            begin
                // noise: loose beats with random command and last
                foreach (p[i]) p[i] = rand_word();
                foreach (e[i]) e[i] = rand_word();
                foreach (c[i]) c[i] = rand_word();
                send_beat(1'($urandom_range(0, 1)), p, e, c, rand_word(),
                          1'($urandom_range(0, 1)));
                sent++;
            end
            else
            begin
                foreach (own[i]) own[i] = rand_word();
                foreach (e[i]) e[i] = rand_word();
                foreach (c[i]) c[i] = rand_word();
                springs = $urandom_range(0, 4);
                start_node(own, e, c, springs == 0);
                sent++;
                for (int k = 0; k < springs; k++)
                begin
                    case ($urandom_range(0, 3))
                        0: foreach (p[i]) p[i] = rand_word();
                        1: p = own;
                        default: foreach (p[i])
                            p[i] = own[i] + word_t'($urandom_range(0, 1 << 20)) - (1 << 19);
                    endcase
                    add_spring(p, rand_word(), k == springs - 1);
                    sent++;
                end
            end
        end
    endtask

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_orphan_springs();
        test_extremes();
        test_zero_length();
        test_random_nodes(1300);
        start <= 1'b0;
        while (pending_forces.size() != 0) @(posedge clk);
        repeat (400) @(posedge clk);
        if (mismatch_count == 0 && pending_forces.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    initial
    begin
        #20_000_000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule
